// ----- design/ookpw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ookpw_pkg
// Shared types and constants for the OOK pulse-width frame decoder.
// ----------------------------------------------------------------------------
package ookpw_pkg;

   localparam int unsigned WIDTH_W   = 16;
   localparam int unsigned OUT_BYTES = 5;
   localparam int unsigned CSR_IDX_W = 4;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_ZERO_MAX   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_END_MIN    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_GAP_LOW   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_GAP_HIGH  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_HIGH_LOW  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_HIGH_HIGH = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_GAP_MIN   = 4'd7;

   // register reset values
   localparam logic [WIDTH_W-1:0] RST_MIN_PULSE      = 16'd391;
   localparam logic [WIDTH_W-1:0] RST_BIT_ZERO_MAX   = 16'd1100;
   localparam logic [WIDTH_W-1:0] RST_BIT_END_MIN    = 16'd2010;
   localparam logic [WIDTH_W-1:0] RST_SYNC_GAP_LOW   = 16'd8500;
   localparam logic [WIDTH_W-1:0] RST_SYNC_GAP_HIGH  = 16'd9000;
   localparam logic [WIDTH_W-1:0] RST_DATA_HIGH_LOW  = 16'd470;
   localparam logic [WIDTH_W-1:0] RST_DATA_HIGH_HIGH = 16'd600;
   localparam logic [WIDTH_W-1:0] RST_LONG_GAP_MIN   = 16'd45000;

   // fixed preamble windows, all bounds exclusive
   localparam logic [WIDTH_W-1:0] SYNC_HIGH_LO = 16'd500;
   localparam logic [WIDTH_W-1:0] SYNC_HIGH_HI = 16'd590;
   localparam logic [WIDTH_W-1:0] SYNC_LOW_LO  = 16'd390;
   localparam logic [WIDTH_W-1:0] SYNC_LOW_HI  = 16'd470;
   localparam logic [WIDTH_W-1:0] END_SYNC_HI  = 16'd11100;

   localparam logic [1:0] PREAMBLE_LAST = 2'd2;
   localparam logic [1:0] PREAMBLE_MAX  = 2'd3;

   // kind of the gap that ended a frame
   localparam logic [1:0] END_LONG_GAP  = 2'd0;
   localparam logic [1:0] END_SYNC_GAP  = 2'd1;
   localparam logic [1:0] END_OTHER_GAP = 2'd2;

   typedef struct packed {
      logic [WIDTH_W-1:0] min_pulse;
      logic [WIDTH_W-1:0] bit_zero_max;
      logic [WIDTH_W-1:0] bit_end_min;
      logic [WIDTH_W-1:0] sync_gap_low;
      logic [WIDTH_W-1:0] sync_gap_high;
      logic [WIDTH_W-1:0] data_high_low;
      logic [WIDTH_W-1:0] data_high_high;
      logic [WIDTH_W-1:0] long_gap_min;
   } cfg_type;

   // commands from the pulse sequencer to the byte store
   typedef struct packed {
      logic frame_start;
      logic take_bit;
      logic bit_value;
   } store_ctl_type;

   // snapshot of the byte store for a result
   typedef struct packed {
      logic [OUT_BYTES-1:0][7:0] bytes;
      logic [2:0]                bytes_done;
      logic [2:0]                bits_pending;
      logic                      overflow;
   } store_view_type;

endpackage

// ----- design/ookpw_byte_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ookpw_byte_store
// Frame byte buffer: packs data bits MSB-first, tracks byte index, bit count
// and the overflow flag of the current frame.
// ----------------------------------------------------------------------------
module ookpw_byte_store #(
   parameter int unsigned FRAME_BYTES = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ookpw_pkg::store_ctl_type ctl,
   output ookpw_pkg::store_view_type view
);

   localparam int unsigned IDX_W = $clog2(FRAME_BYTES + 1);

   logic [7:0]       frame_ff [FRAME_BYTES];
   logic [7:0]       frame_in [FRAME_BYTES];
   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [2:0]       bit_count_ff, bit_count_in;
   logic             overflow_ff, overflow_in;

   logic [IDX_W:0]   index_inc;
   logic             byte_done;
   logic [IDX_W+2:0] index_wide;

   assign index_inc = {1'b0, byte_index_ff} + {{IDX_W{1'b0}}, 1'b1};
   assign byte_done = ctl.take_bit && (bit_count_ff == 3'd7);

   always_comb begin
      byte_index_in = byte_index_ff;
      bit_count_in  = bit_count_ff;
      overflow_in   = overflow_ff;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         frame_in[i] = frame_ff[i];
      end
      if (ctl.frame_start) begin
         byte_index_in = '0;
         bit_count_in  = '0;
         overflow_in   = 1'b0;
         frame_in[0]   = '0;
      end else if (ctl.take_bit) begin
         for (int i = 0; i < FRAME_BYTES; i++) begin
            if (byte_index_ff == IDX_W'(i)) begin
               frame_in[i] = {frame_ff[i][6:0], ctl.bit_value};
            end
         end
         bit_count_in = bit_count_ff + 3'd1;
         if (byte_done) begin
            if (index_inc > (IDX_W + 1)'(FRAME_BYTES)) begin
               // surplus byte finished: wrap, byte 0 keeps its contents
               byte_index_in = '0;
               overflow_in   = 1'b1;
            end else begin
               byte_index_in = index_inc[IDX_W-1:0];
               for (int i = 0; i < FRAME_BYTES; i++) begin
                  if (index_inc == (IDX_W + 1)'(i)) begin
                     frame_in[i] = '0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         bit_count_ff  <= '0;
         overflow_ff   <= 1'b0;
         for (int i = 0; i < FRAME_BYTES; i++) begin
            frame_ff[i] <= '0;
         end
      end else begin
         byte_index_ff <= byte_index_in;
         bit_count_ff  <= bit_count_in;
         overflow_ff   <= overflow_in;
         for (int i = 0; i < FRAME_BYTES; i++) begin
            frame_ff[i] <= frame_in[i];
         end
      end
   end

   assign index_wide = {3'b000, byte_index_ff};

   generate
      for (genvar k = 0; k < ookpw_pkg::OUT_BYTES; k++) begin : g_view
         if (k < FRAME_BYTES) begin : g_live
            assign view.bytes[k] = frame_ff[k];
         end else begin : g_none
            assign view.bytes[k] = '0;
         end
      end
   endgenerate

   assign view.bytes_done   = index_wide[2:0];
   assign view.bits_pending = bit_count_ff;
   assign view.overflow     = overflow_ff;

endmodule

// ----- design/ook_pulse_width_frame_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ook_pulse_width_frame_decoder_core
// OOK pulse-width decoder: finds the sync preamble, reads data bits from low
// pulse widths and reports each frame when an end gap arrives.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pulse width (microseconds) per transfer. rsp_* carries
//   one frame result (five bytes, counts, end gap kind, overflow) per frame.
//   csr_* writes the eight 16-bit thresholds; index 8 and up is ignored.
// Throughput: one pulse per cycle unless stalled. Each pulse is decoded by
//   a single compare and shift pass between input and result register.
// Latency: the result of a frame is valid the cycle after the transfer of
//   its ending pulse.
// Stall: while a result waits on rsp_ready, pulses keep flowing except when
//   the decoder expects a data low pulse, the only pulse that can end a
//   frame; then req_ready follows rsp_ready.
// Reset: thresholds return to defaults, the decoder hunts for sync, the
//   frame buffer, counts and overflow clear and no result is pending.
// ----------------------------------------------------------------------------
module ook_pulse_width_frame_decoder_core #(
   parameter int unsigned FRAME_BYTES = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_pulse_width,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_byte_0,
   output logic [7:0]  rsp_byte_1,
   output logic [7:0]  rsp_byte_2,
   output logic [7:0]  rsp_byte_3,
   output logic [7:0]  rsp_byte_4,
   output logic [2:0]  rsp_bytes_done,
   output logic [2:0]  rsp_bits_pending,
   output logic [1:0]  rsp_end_kind,
   output logic        rsp_overflow,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   typedef enum logic [2:0] {
      PH_SYNC_HIGH = 3'd0,
      PH_SYNC_LOW  = 3'd1,
      PH_SYNC_GAP  = 3'd2,
      PH_DATA_HIGH = 3'd3,
      PH_DATA_LOW  = 3'd4
   } phase_type;

   ookpw_pkg::cfg_type        cfg_ff;
   phase_type                 phase_ff, phase_in;
   logic [1:0]                preamble_ff, preamble_in;
   ookpw_pkg::store_ctl_type  ctl;
   ookpw_pkg::store_view_type view;

   logic        rsp_valid_ff;
   logic [ookpw_pkg::OUT_BYTES-1:0][7:0] rsp_bytes_ff;
   logic [2:0]  rsp_bytes_done_ff, rsp_bits_pending_ff;
   logic [1:0]  rsp_end_kind_ff, end_kind;
   logic        rsp_overflow_ff;

   logic        accept, live, emit;
   logic [15:0] w;

   // only an expected data low can produce a result
   assign req_ready = !rsp_valid_ff || rsp_ready || (phase_ff != PH_DATA_LOW);
   assign accept    = req_valid && req_ready;
   assign w         = req_pulse_width;
   assign live      = accept && (w > cfg_ff.min_pulse);

   always_comb begin
      phase_in        = phase_ff;
      preamble_in     = preamble_ff;
      ctl.frame_start = 1'b0;
      ctl.take_bit    = 1'b0;
      ctl.bit_value   = !(w < cfg_ff.bit_zero_max);
      emit            = 1'b0;
      if (live) begin
         unique case (phase_ff)
            PH_SYNC_LOW: begin
               if (w > ookpw_pkg::SYNC_LOW_LO && w < ookpw_pkg::SYNC_LOW_HI) begin
                  if (preamble_ff < ookpw_pkg::PREAMBLE_MAX) begin
                     preamble_in = preamble_ff + 2'd1;
                  end
               end else begin
                  preamble_in = '0;
               end
               phase_in = PH_SYNC_HIGH;
            end
            PH_SYNC_GAP: begin
               if (w > cfg_ff.sync_gap_low && w < cfg_ff.sync_gap_high) begin
                  ctl.frame_start = 1'b1;
                  phase_in        = PH_DATA_HIGH;
               end else begin
                  phase_in = PH_SYNC_HIGH;
               end
            end
            PH_DATA_HIGH: begin
               if (w > cfg_ff.data_high_low && w < cfg_ff.data_high_high) begin
                  phase_in = PH_DATA_LOW;
               end else begin
                  phase_in = PH_SYNC_HIGH;
               end
            end
            PH_DATA_LOW: begin
               if (w < cfg_ff.bit_end_min) begin
                  ctl.take_bit = 1'b1;
                  phase_in     = PH_DATA_HIGH;
               end else begin
                  emit     = 1'b1;
                  phase_in = PH_SYNC_HIGH;
               end
            end
            default: begin
               // hunting sync high, unused codes land here too
               phase_in = PH_SYNC_HIGH;
               if (w > ookpw_pkg::SYNC_HIGH_LO && w < ookpw_pkg::SYNC_HIGH_HI) begin
                  if (preamble_ff == ookpw_pkg::PREAMBLE_LAST) begin
                     preamble_in = '0;
                     phase_in    = PH_SYNC_GAP;
                  end else begin
                     phase_in = PH_SYNC_LOW;
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      priority if (w > cfg_ff.long_gap_min) begin
         end_kind = ookpw_pkg::END_LONG_GAP;
      end else if (w > cfg_ff.sync_gap_low && w < ookpw_pkg::END_SYNC_HI) begin
         end_kind = ookpw_pkg::END_SYNC_GAP;
      end else begin
         end_kind = ookpw_pkg::END_OTHER_GAP;
      end
   end

   ookpw_byte_store #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .ctl  (ctl),
      .view (view)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC_HIGH;
         preamble_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         preamble_ff <= preamble_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_bytes_ff        <= view.bytes;
         rsp_bytes_done_ff   <= view.bytes_done;
         rsp_bits_pending_ff <= view.bits_pending;
         rsp_end_kind_ff     <= end_kind;
         rsp_overflow_ff     <= view.overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pulse      <= ookpw_pkg::RST_MIN_PULSE;
         cfg_ff.bit_zero_max   <= ookpw_pkg::RST_BIT_ZERO_MAX;
         cfg_ff.bit_end_min    <= ookpw_pkg::RST_BIT_END_MIN;
         cfg_ff.sync_gap_low   <= ookpw_pkg::RST_SYNC_GAP_LOW;
         cfg_ff.sync_gap_high  <= ookpw_pkg::RST_SYNC_GAP_HIGH;
         cfg_ff.data_high_low  <= ookpw_pkg::RST_DATA_HIGH_LOW;
         cfg_ff.data_high_high <= ookpw_pkg::RST_DATA_HIGH_HIGH;
         cfg_ff.long_gap_min   <= ookpw_pkg::RST_LONG_GAP_MIN;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ookpw_pkg::CSR_MIN_PULSE:      cfg_ff.min_pulse      <= csr_write_data;
            ookpw_pkg::CSR_BIT_ZERO_MAX:   cfg_ff.bit_zero_max   <= csr_write_data;
            ookpw_pkg::CSR_BIT_END_MIN:    cfg_ff.bit_end_min    <= csr_write_data;
            ookpw_pkg::CSR_SYNC_GAP_LOW:   cfg_ff.sync_gap_low   <= csr_write_data;
            ookpw_pkg::CSR_SYNC_GAP_HIGH:  cfg_ff.sync_gap_high  <= csr_write_data;
            ookpw_pkg::CSR_DATA_HIGH_LOW:  cfg_ff.data_high_low  <= csr_write_data;
            ookpw_pkg::CSR_DATA_HIGH_HIGH: cfg_ff.data_high_high <= csr_write_data;
            ookpw_pkg::CSR_LONG_GAP_MIN:   cfg_ff.long_gap_min   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_0       = rsp_bytes_ff[0];
   assign rsp_byte_1       = rsp_bytes_ff[1];
   assign rsp_byte_2       = rsp_bytes_ff[2];
   assign rsp_byte_3       = rsp_bytes_ff[3];
   assign rsp_byte_4       = rsp_bytes_ff[4];
   assign rsp_bytes_done   = rsp_bytes_done_ff;
   assign rsp_bits_pending = rsp_bits_pending_ff;
   assign rsp_end_kind     = rsp_end_kind_ff;
   assign rsp_overflow     = rsp_overflow_ff;

endmodule
